// ===== rtl/ses_pkg.sv =====
`timescale 1ns / 1ps

package ses_pkg;

  localparam int DATA_W = 32;

  // input word: one element of the set
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_word_t;

  // output word: one element in descending order
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflow;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_START,
    ST_LOAD,
    ST_TOP,
    ST_SWEEP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } seq_state_t;

endpackage

// ===== rtl/ses_store.sv =====
`timescale 1ns / 1ps

module ses_store #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic signed [ses_pkg::DATA_W-1:0] wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic signed [ses_pkg::DATA_W-1:0] rd_data
);

  logic signed [ses_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ses_seq.sv =====
`timescale 1ns / 1ps

module ses_seq #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ses_pkg::in_word_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output ses_pkg::out_word_t                out_data,
  // store ports
  output logic                              wr_en,
  output logic [$clog2(DEPTH)-1:0]          wr_addr,
  output logic signed [ses_pkg::DATA_W-1:0] wr_data,
  output logic                              rd_en,
  output logic [$clog2(DEPTH)-1:0]          rd_addr,
  input  logic signed [ses_pkg::DATA_W-1:0] rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ses_pkg::seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]                  fill_r;
  logic                              dropped_r;
  logic [IDX_W-1:0]                  top_idx_r;
  logic [IDX_W-1:0]                  lo_r;
  logic                              more_r;
  logic                              pend_r;
  logic [IDX_W-1:0]                  pend_addr_r;
  logic signed [ses_pkg::DATA_W-1:0] top_r;
  logic [IDX_W-1:0]                  emit_r;
  ses_pkg::out_word_t                out_r;
  logic                              out_valid_r;

  logic             in_acc;
  logic             out_acc;
  logic             full;
  logic             swap;
  logic             pass_done;
  logic             last_emit;
  logic [CNT_W-1:0] fill_m1;

  assign in_acc    = in_valid && (state_r == ses_pkg::ST_FILL);
  assign out_acc   = out_valid_r && !out_stall;
  assign full      = (fill_r == CNT_W'(DEPTH));
  assign fill_m1   = fill_r - CNT_W'(1);
  assign swap      = pend_r && (top_r > rd_data);
  assign pass_done = !pend_r && !more_r;
  assign last_emit = (emit_r == fill_m1[IDX_W-1:0]);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ses_pkg::ST_FILL: begin
        if (in_acc && in_data.last_item) state_nxt = ses_pkg::ST_START;
      end
      ses_pkg::ST_START: begin
        state_nxt = (fill_r > CNT_W'(1)) ? ses_pkg::ST_LOAD : ses_pkg::ST_EMIT_RD;
      end
      ses_pkg::ST_LOAD:  state_nxt = ses_pkg::ST_TOP;
      ses_pkg::ST_TOP:   state_nxt = ses_pkg::ST_SWEEP;
      ses_pkg::ST_SWEEP: begin
        if (pass_done) begin
          state_nxt = (top_idx_r == IDX_W'(1)) ? ses_pkg::ST_EMIT_RD : ses_pkg::ST_LOAD;
        end
      end
      ses_pkg::ST_EMIT_RD: state_nxt = ses_pkg::ST_EMIT_LD;
      ses_pkg::ST_EMIT_LD: state_nxt = ses_pkg::ST_EMIT_WAIT;
      ses_pkg::ST_EMIT_WAIT: begin
        if (out_acc) state_nxt = last_emit ? ses_pkg::ST_FILL : ses_pkg::ST_EMIT_LD;
      end
      default: state_nxt = ses_pkg::ST_FILL;
    endcase
  end

  // store access and input stall
  always_comb begin
    in_stall = (state_r != ses_pkg::ST_FILL);
    wr_en    = 1'b0;
    wr_addr  = pend_addr_r;
    wr_data  = top_r;
    rd_en    = 1'b0;
    rd_addr  = lo_r;
    case (state_r)
      ses_pkg::ST_FILL: begin
        wr_en   = in_acc && !full;
        wr_addr = fill_r[IDX_W-1:0];
        wr_data = in_data.value;
      end
      ses_pkg::ST_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = top_idx_r;
      end
      ses_pkg::ST_TOP: begin
        rd_en = 1'b1;
      end
      ses_pkg::ST_SWEEP: begin
        // lower entry written back on swap; the running minimum lands on top at pass end
        rd_en = more_r;
        if (pass_done) begin
          wr_en   = 1'b1;
          wr_addr = top_idx_r;
        end else begin
          wr_en = swap;
        end
      end
      ses_pkg::ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = emit_r;
      end
      ses_pkg::ST_EMIT_WAIT: begin
        rd_en   = out_acc && !last_emit;
        rd_addr = emit_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ses_pkg::ST_FILL;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ses_pkg::ST_FILL: begin
          if (in_acc) begin
            if (full) dropped_r <= 1'b1;
            else      fill_r    <= fill_r + CNT_W'(1);
          end
        end
        ses_pkg::ST_LOAD: begin
          more_r <= 1'b1;
        end
        ses_pkg::ST_TOP: begin
          pend_r <= 1'b1;
          if (lo_r == '0) more_r <= 1'b0;
        end
        ses_pkg::ST_SWEEP: begin
          pend_r <= more_r;
          if (more_r && lo_r == '0) more_r <= 1'b0;
        end
        ses_pkg::ST_EMIT_LD: begin
          out_valid_r <= 1'b1;
        end
        ses_pkg::ST_EMIT_WAIT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (last_emit) begin
              fill_r    <= '0;
              dropped_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ses_pkg::ST_START: begin
        top_idx_r <= fill_m1[IDX_W-1:0];
        emit_r    <= '0;
      end
      ses_pkg::ST_LOAD: begin
        lo_r <= top_idx_r - IDX_W'(1);
      end
      ses_pkg::ST_TOP: begin
        top_r       <= rd_data;
        pend_addr_r <= lo_r;
        if (lo_r != '0) lo_r <= lo_r - IDX_W'(1);
      end
      ses_pkg::ST_SWEEP: begin
        if (swap) top_r <= rd_data;
        if (more_r) begin
          pend_addr_r <= lo_r;
          if (lo_r != '0) lo_r <= lo_r - IDX_W'(1);
        end
        if (pass_done) top_idx_r <= top_idx_r - IDX_W'(1);
      end
      ses_pkg::ST_EMIT_LD: begin
        out_r.sorted_value <= rd_data;
        out_r.last_result  <= last_emit;
        out_r.overflow     <= dropped_r;
      end
      ses_pkg::ST_EMIT_WAIT: begin
        if (out_acc && !last_emit) emit_r <= emit_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/stack_exchange_sort_unit.sv =====
`timescale 1ns / 1ps
// Collects a set of signed 32-bit words and returns them largest first.
// Input channel (in_valid/in_stall/in_data): one value per word; the word
// with last_item set closes the set. Words past DEPTH are dropped and every
// result of that set carries overflow. in_stall is high from the closing
// word until the last result of the set has been taken.
// Result channel (out_valid/out_stall/out_data): one word per held entry,
// index order, last_result on the final one. A stalled result is held in the
// output register until taken.
// The sort keeps the pass's top entry in a register and sweeps the lower
// entries through the single read port of the store, one compare per cycle.
// Emission starts once the sort is done; each result is read from the store
// into the output register and held there until taken.
// Reset: synchronous, active low; empties the set and clears the flags. The
// store contents are not cleared; only entries of the current set are read.
module stack_exchange_sort_unit #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ses_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ses_pkg::out_word_t  out_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  logic signed [ses_pkg::DATA_W-1:0] wr_data;
  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic signed [ses_pkg::DATA_W-1:0] rd_data;

  ses_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  ses_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // no new word is taken while results are pending
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("input accepted during emission");

  // closing word locks the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_item) |=> in_stall)
    else $error("input not stalled after closing word");

  // final result ends the emission
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_result) |=> (!out_valid && !in_stall))
    else $error("emission did not end after final result");

endmodule
